[rtl/bvdg_pkg.sv]
// Package for the battery voltage debounce gauge.
// Holds field widths, register reset values, register indexes and the sequencer states.
// No dependencies.
package bvdg_pkg;

    localparam int DEF_ADC_BITS = 10;

    localparam int BGMV_W   = 11;
    localparam int RATIO_W  = 4;
    localparam int THR_W    = 10;
    localparam int CONF_W   = 4;
    localparam int MV_W     = 16;
    localparam int PCT_W    = 7;
    localparam int JCNT_W   = 4;

    localparam logic [BGMV_W-1:0]  RST_BANDGAP_MV = 11'd1190;
    localparam logic [RATIO_W-1:0] RST_RATIO      = 4'd2;
    localparam logic [THR_W-1:0]   RST_THRESHOLD  = 10'd50;
    localparam logic [CONF_W-1:0]  RST_CONFIRM    = 4'd3;

    localparam logic [MV_W-1:0]  PCT_LOW_MV  = 16'd3300;
    localparam logic [MV_W-1:0]  PCT_HIGH_MV = 16'd4200;
    localparam logic [PCT_W-1:0] PCT_FULL    = 7'd100;
    localparam logic [PCT_W-1:0] PCT_EMPTY   = 7'd0;

    // x/9 for x in 0..900 as (x*3641) >> 15
    localparam int PCT_MUL_W = 22;
    localparam int PCT_SHIFT = 15;
    localparam logic [11:0] PCT_RECIP = 12'd3641;

    typedef enum logic [1:0] {
        REG_BANDGAP_MV,
        REG_DIVIDER_RATIO,
        REG_JUMP_THRESHOLD,
        REG_CONFIRM_NEEDED
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VCC,
        S_VCC_W,
        S_RAW,
        S_SCALE,
        S_UPD,
        S_PCT,
        S_OUT
    } t_state;

endpackage

[rtl/bvdg_if.sv]
// Valid/ready channel interfaces for the battery gauge.
// Input channel carries the ADC codes, output channel the gauge result.
// Depends on bvdg_pkg.
interface bvdg_in_if #(
    parameter int ADC_BITS = bvdg_pkg::DEF_ADC_BITS
);
    logic                valid;
    logic                ready;
    logic [ADC_BITS-1:0] bandgap_code;
    logic [ADC_BITS-1:0] battery_code;

    modport source (output valid, output bandgap_code, output battery_code, input ready);
    modport sink   (input valid, input bandgap_code, input battery_code, output ready);
endinterface

interface bvdg_out_if;
    logic                         valid;
    logic                         ready;
    logic [bvdg_pkg::MV_W-1:0]    stable_mv;
    logic [bvdg_pkg::PCT_W-1:0]   charge_percent;
    logic [bvdg_pkg::JCNT_W-1:0]  pending_count;

    modport source (output valid, output stable_mv, output charge_percent,
                    output pending_count, input ready);
    modport sink   (input valid, input stable_mv, input charge_percent,
                    input pending_count, output ready);
endinterface

[rtl/bvdg_div.sv]
// Restoring serial divider, one quotient bit per cycle.
// Used by the gauge sequencer; no package dependencies.
module bvdg_div #(
    parameter int DIVD_W = 31,
    parameter int DIVS_W = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DIVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_dvs;

    logic [DIVS_W:0]   n_trial;
    logic [DIVS_W:0]   n_diff;
    logic              n_ge;

    always_comb begin
        n_trial = {r_rem, r_quo[DIVD_W-1]};
        n_ge    = (n_trial >= {1'b0, r_dvs});
        n_diff  = n_trial - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVD_W-2:0], n_ge};
            r_rem <= n_ge ? n_diff[DIVS_W-1:0] : n_trial[DIVS_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/battery_voltage_debounce_gauge_top.sv]
// Battery voltage gauge with jump debounce: ratiometric supply and battery mV, percent.
// Steps: supply divide in the serial divider, battery product folded to divide by
// 2^ADC_BITS-1, scale, update, percent; a zero bandgap code skips to the update with 0 mV.
// One transaction at a time: ready only while idle; output stalls hold the result.
// Reset (synchronous, active low): registers to defaults, stable voltage and count to 0.
// Depends on bvdg_pkg, bvdg_if and bvdg_div.
module battery_voltage_debounce_gauge_top #(
    parameter int ADC_BITS = bvdg_pkg::DEF_ADC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bvdg_in_if.sink     i_in,
    bvdg_out_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int VCC_W  = bvdg_pkg::BGMV_W + ADC_BITS;
    localparam int PROD_W = ADC_BITS + VCC_W;
    localparam int SCL_W  = VCC_W + bvdg_pkg::RATIO_W;
    localparam int MV_W   = bvdg_pkg::MV_W;
    localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

    // configuration
    logic [bvdg_pkg::BGMV_W-1:0]  r_bandgap_mv;
    logic [bvdg_pkg::RATIO_W-1:0] r_ratio;
    logic [bvdg_pkg::THR_W-1:0]   r_threshold;
    logic [bvdg_pkg::CONF_W-1:0]  r_confirm;
    bvdg_pkg::t_reg_idx           w_idx;
    logic                         w_wr;

    assign pready = 1'b1;
    assign w_idx  = bvdg_pkg::t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bandgap_mv <= bvdg_pkg::RST_BANDGAP_MV;
            r_ratio      <= bvdg_pkg::RST_RATIO;
            r_threshold  <= bvdg_pkg::RST_THRESHOLD;
            r_confirm    <= bvdg_pkg::RST_CONFIRM;
        end else if (w_wr) begin
            case (w_idx)
                bvdg_pkg::REG_BANDGAP_MV:     r_bandgap_mv <= pwdata[bvdg_pkg::BGMV_W-1:0];
                bvdg_pkg::REG_DIVIDER_RATIO:  r_ratio      <= pwdata[bvdg_pkg::RATIO_W-1:0];
                bvdg_pkg::REG_JUMP_THRESHOLD: r_threshold  <= pwdata[bvdg_pkg::THR_W-1:0];
                bvdg_pkg::REG_CONFIRM_NEEDED: r_confirm    <= pwdata[bvdg_pkg::CONF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            bvdg_pkg::REG_BANDGAP_MV:     prdata = 32'(r_bandgap_mv);
            bvdg_pkg::REG_DIVIDER_RATIO:  prdata = 32'(r_ratio);
            bvdg_pkg::REG_JUMP_THRESHOLD: prdata = 32'(r_threshold);
            bvdg_pkg::REG_CONFIRM_NEEDED: prdata = 32'(r_confirm);
            default:                      prdata = '0;
        endcase
    end

    // sequencer
    bvdg_pkg::t_state r_state, n_state;

    logic                r_o_valid;
    logic [MV_W-1:0]     r_o_mv;
    logic [bvdg_pkg::PCT_W-1:0]  r_o_pct;
    logic [bvdg_pkg::JCNT_W-1:0] r_o_cnt;

    logic [ADC_BITS-1:0] r_bg;
    logic [ADC_BITS-1:0] r_bat;
    logic [PROD_W-1:0]   r_prod;
    logic [VCC_W-1:0]    r_raw;
    logic [MV_W-1:0]     r_mv;
    logic [MV_W-1:0]     r_stable;
    logic [bvdg_pkg::JCNT_W-1:0] r_jump;
    logic [bvdg_pkg::PCT_W-1:0]  r_pct;

    logic                w_accept;
    logic                w_load;
    logic                w_div_start;
    logic [VCC_W-1:0]    w_div_dividend;
    logic                w_div_done;
    logic [VCC_W-1:0]    w_div_quo;
    logic [VCC_W-1:0]    w_fold_hi;
    logic [ADC_BITS-1:0] w_fold_lo;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_load   = (r_state == bvdg_pkg::S_OUT) && (!r_o_valid || o_res.ready);

    // divide by 2^ADC_BITS-1: x = hi*ADC_MAX + (hi + lo), folded until hi is zero
    assign w_fold_hi = r_prod[PROD_W-1:ADC_BITS];
    assign w_fold_lo = r_prod[ADC_BITS-1:0];

    assign w_div_dividend = VCC_W'(r_bandgap_mv) * VCC_W'(ADC_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bvdg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        i_in.ready  = 1'b0;
        w_div_start = 1'b0;
        case (r_state)
            bvdg_pkg::S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = (i_in.bandgap_code == '0) ? bvdg_pkg::S_UPD : bvdg_pkg::S_VCC;
                end
            end
            bvdg_pkg::S_VCC: begin
                w_div_start = 1'b1;
                n_state     = bvdg_pkg::S_VCC_W;
            end
            bvdg_pkg::S_VCC_W: begin
                if (w_div_done) begin
                    n_state = bvdg_pkg::S_RAW;
                end
            end
            bvdg_pkg::S_RAW: begin
                if (w_fold_hi == '0) begin
                    n_state = bvdg_pkg::S_SCALE;
                end
            end
            bvdg_pkg::S_SCALE: n_state = bvdg_pkg::S_UPD;
            bvdg_pkg::S_UPD:   n_state = bvdg_pkg::S_PCT;
            bvdg_pkg::S_PCT:   n_state = bvdg_pkg::S_OUT;
            bvdg_pkg::S_OUT: begin
                if (w_load) begin
                    n_state = bvdg_pkg::S_IDLE;
                end
            end
            default: n_state = bvdg_pkg::S_IDLE;
        endcase
    end

    bvdg_div #(
        .DIVD_W (VCC_W),
        .DIVS_W (ADC_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (r_bg),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // datapath
    logic [SCL_W-1:0]  w_scaled;
    logic [MV_W-1:0]   w_diff;
    logic [bvdg_pkg::JCNT_W-1:0] w_jump_inc;
    logic [MV_W-1:0]   w_pct_off;
    logic [bvdg_pkg::PCT_MUL_W-1:0] w_pct_mul;

    assign w_scaled   = SCL_W'(r_raw) * SCL_W'(r_ratio);
    assign w_diff     = (r_mv > r_stable) ? (r_mv - r_stable) : (r_stable - r_mv);
    assign w_jump_inc = r_jump + 1'b1;
    assign w_pct_off  = r_stable - bvdg_pkg::PCT_LOW_MV;
    assign w_pct_mul  = bvdg_pkg::PCT_MUL_W'(w_pct_off[9:0])
                      * bvdg_pkg::PCT_MUL_W'(bvdg_pkg::PCT_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= '0;
            r_jump   <= '0;
        end else if (r_state == bvdg_pkg::S_UPD) begin
            if (w_diff <= MV_W'(r_threshold)) begin
                r_stable <= r_mv;
                r_jump   <= '0;
            end else if (w_jump_inc >= r_confirm) begin
                r_stable <= r_mv;
                r_jump   <= '0;
            end else begin
                r_jump   <= w_jump_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bg  <= i_in.bandgap_code;
            r_bat <= i_in.battery_code;
            r_mv  <= '0;
        end
        if (r_state == bvdg_pkg::S_VCC_W && w_div_done) begin
            r_prod <= PROD_W'(r_bat) * PROD_W'(w_div_quo);
            r_raw  <= '0;
        end
        if (r_state == bvdg_pkg::S_RAW) begin
            if (w_fold_hi != '0) begin
                r_prod <= PROD_W'(w_fold_hi) + PROD_W'(w_fold_lo);
                r_raw  <= r_raw + w_fold_hi;
            end else if (w_fold_lo == ADC_MAX) begin
                r_raw  <= r_raw + 1'b1;
            end
        end
        if (r_state == bvdg_pkg::S_SCALE) begin
            r_mv <= (|w_scaled[SCL_W-1:MV_W]) ? {MV_W{1'b1}} : w_scaled[MV_W-1:0];
        end
        if (r_state == bvdg_pkg::S_PCT) begin
            if (r_stable < bvdg_pkg::PCT_LOW_MV) begin
                r_pct <= bvdg_pkg::PCT_EMPTY;
            end else if (r_stable > bvdg_pkg::PCT_HIGH_MV) begin
                r_pct <= bvdg_pkg::PCT_FULL;
            end else begin
                r_pct <= w_pct_mul[bvdg_pkg::PCT_SHIFT +: bvdg_pkg::PCT_W];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_mv  <= r_stable;
            r_o_pct <= r_pct;
            r_o_cnt <= r_jump;
        end
    end

    assign o_res.valid          = r_o_valid;
    assign o_res.stable_mv      = r_o_mv;
    assign o_res.charge_percent = r_o_pct;
    assign o_res.pending_count  = r_o_cnt;

endmodule
